[sv/sat_pkg.sv]
// Package with shared types and constants for the session affinity table.
`default_nettype none
package sat_pkg;
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW = $clog2(TableDepth);
  localparam int unsigned CntW = $clog2(TableDepth + 1);

  typedef enum logic [1:0] {
    REQ_QUERY = 2'd0,
    REQ_END   = 2'd1,
    REQ_BIND  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_BEGIN = 2'd1,
    KIND_END   = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    ST_NO_ENTRY  = 4'd0,
    ST_HIT       = 4'd1,
    ST_APPENDED  = 4'd2,
    ST_EVICTED   = 4'd3,
    ST_ALL_BUSY  = 4'd4,
    ST_REMOVED   = 4'd5,
    ST_ABSENT    = 4'd6,
    ST_BOUND     = 4'd7,
    ST_NOT_BOUND = 4'd8
  } status_e;

  typedef struct packed {
    logic [63:0] key;
    logic [15:0] backend;
    logic        txn;
    logic [31:0] last_use;
  } entry_t;

  // Commands broadcast to every cell in the chain.
  typedef struct packed {
    logic          write;    // write selected entry
    logic [IdxW-1:0] widx;
    entry_t        wdata;
    logic          shift;    // compact: cells at or above sidx take their upper neighbor
    logic [IdxW-1:0] sidx;
  } cell_cmd_t;
endpackage
`default_nettype wire

[sv/sat_cell.sv]
// One table cell: holds an entry, compares its key and forwards the oldest candidate.
`default_nettype none
module sat_cell (
  input  wire                         clk_i,
  input  wire  [sat_pkg::IdxW-1:0]    index_i,
  input  wire                         live_i,
  input  wire  [63:0]                 key_i,
  input  sat_pkg::cell_cmd_t          cmd_i,
  input  sat_pkg::entry_t             upper_i,
  output sat_pkg::entry_t             entry_o,
  output logic                        match_o,
  // Oldest-candidate chain, passed from lower to higher index.
  input  wire                         best_vld_i,
  input  wire  [sat_pkg::IdxW-1:0]    best_idx_i,
  input  wire  [31:0]                 best_age_i,
  output logic                        best_vld_o,
  output logic [sat_pkg::IdxW-1:0]    best_idx_o,
  output logic [31:0]                 best_age_o
);
  import sat_pkg::*;
  entry_t entry_q;
  logic   take;
  logic            best_vld_q;
  logic [IdxW-1:0] best_idx_q;
  logic [31:0]     best_age_q;

  assign entry_o = entry_q;
  assign match_o = live_i && (entry_q.key == key_i);
  assign take = live_i && !entry_q.txn &&
                (!best_vld_i || (entry_q.last_use < best_age_i));
  assign best_vld_o = best_vld_q;
  assign best_idx_o = best_idx_q;
  assign best_age_o = best_age_q;

  // The candidate is registered, so it moves one cell further in every cycle.
  always_ff @(posedge clk_i) begin
    best_vld_q <= best_vld_i || take;
    best_idx_q <= take ? index_i : best_idx_i;
    best_age_q <= take ? entry_q.last_use : best_age_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && cmd_i.widx == index_i) begin
      entry_q <= cmd_i.wdata;
    end else if (cmd_i.shift && index_i >= cmd_i.sidx) begin
      entry_q <= upper_i;
    end
  end
endmodule
`default_nettype wire

[sv/session_affinity_table.sv]
// Top level of the session affinity table: cell chain plus item sequencer.
// The key compare is done in parallel, but the oldest-entry candidate moves
// through the cell chain one cell per cycle during the scan state; the update
// state then updates the table and the result is shown in the next cycle.
// busy_o is high from the accepting edge until the result cycle ends, so the
// next word can be accepted only after that cycle; results cannot be stalled.
// max_entries is written through cfg_we_i/cfg_wdata_i; the user must do so only
// while idle, as the block itself does not enforce it.
`default_nettype none
module session_affinity_table (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  output logic        busy_o,
  input  wire         cfg_we_i,
  input  wire  [6:0]  cfg_wdata_i,
  input  wire  [1:0]  req_type_i,
  input  wire  [63:0] session_key_i,
  input  wire  [1:0]  query_kind_i,
  input  wire         needs_sticky_i,
  input  wire  [31:0] now_seconds_i,
  input  wire  [15:0] acquired_backend_i,
  output logic        done_o,
  output logic [3:0]  status_o,
  output logic        pinned_txn_o,
  output logic [15:0] backend_hint_o,
  output logic [6:0]  live_entries_o
);
  import sat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_UPD = 4'b0100, S_OUT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [6:0]      max_q;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] scan_q;
  logic            scan_last;
  logic [1:0]  req_q;
  logic [63:0] key_q;
  logic [1:0]  kind_q;
  logic        sticky_q;
  logic [31:0] now_q;
  logic [15:0] acq_q;

  entry_t ent [TableDepth];
  logic [TableDepth-1:0] match;
  logic [TableDepth-1:0] live;
  logic                bv [TableDepth+1];
  logic [IdxW-1:0]     bi [TableDepth+1];
  logic [31:0]         ba [TableDepth+1];
  cell_cmd_t cmd;

  logic            hit_q, bvld_q;
  logic [IdxW-1:0] hidx_q, bidx_q;
  logic [IdxW-1:0] hidx;
  logic            hit;

  logic [3:0]  status_q, status_d;
  logic        txn_q, txn_d;
  logic [15:0] hint_q, hint_d;

  assign bv[0] = 1'b0;
  assign bi[0] = '0;
  assign ba[0] = '0;

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    assign live[g] = (CntW'(g) < count_q);
    sat_cell u_cell (
      .clk_i, .index_i(IdxW'(g)), .live_i(live[g]), .key_i(key_q), .cmd_i(cmd),
      .upper_i(ent[(g + 1 < TableDepth) ? g + 1 : g]), .entry_o(ent[g]),
      .match_o(match[g]),
      .best_vld_i(bv[g]), .best_idx_i(bi[g]), .best_age_i(ba[g]),
      .best_vld_o(bv[g+1]), .best_idx_o(bi[g+1]), .best_age_o(ba[g+1])
    );
  end

  // The table only changes in the update cycle, so by the last scan cycle the
  // end of the chain holds the oldest candidate.
  assign scan_last = (scan_q == IdxW'(TableDepth - 1));

  // First matching cell.
  always_comb begin
    hit = 1'b0;
    hidx = '0;
    for (int k = TableDepth - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit = 1'b1;
        hidx = IdxW'(k);
      end
    end
  end

  function automatic logic needs_create();
    return sticky_q || (kind_e'(kind_q) == KIND_BEGIN);
  endfunction

  logic [CntW-1:0] limit;
  entry_t          cur;
  logic            cur_txn;
  logic [15:0]     cur_be;
  always_comb begin
    limit = ({1'b0, max_q} < 8'(TableDepth)) ? CntW'(max_q) : CntW'(TableDepth);
    cmd = '0;
    count_d = count_q;
    status_d = status_q;
    txn_d = txn_q;
    hint_d = hint_q;
    cur = ent[hidx_q];
    cur_txn = 1'b0;
    cur_be = '0;
    if (state_q == S_UPD) begin
      txn_d = 1'b0;
      hint_d = '0;
      status_d = ST_NO_ENTRY;
      unique case (req_e'(req_q))
        REQ_QUERY: begin
          logic have;
          logic [IdxW-1:0] at;
          have = 1'b1;
          at = hidx_q;
          if (hit_q) begin
            status_d = ST_HIT;
          end else if (needs_create()) begin
            if (count_q < limit) begin
              at = count_q[IdxW-1:0];
              cur = '{key: key_q, backend: '0, txn: 1'b0, last_use: now_q};
              count_d = count_q + 1'b1;
              status_d = ST_APPENDED;
            end else if (bvld_q) begin
              at = bidx_q;
              cur = '{key: key_q, backend: '0, txn: 1'b0, last_use: now_q};
              status_d = ST_EVICTED;
            end else begin
              have = 1'b0;
              status_d = ST_ALL_BUSY;
            end
          end else begin
            have = 1'b0;
          end
          if (have) begin
            cur_txn = cur.txn;
            cur_be = cur.backend;
            if (kind_e'(kind_q) == KIND_BEGIN) begin
              cur_txn = 1'b1;
            end else if (kind_e'(kind_q) == KIND_END) begin
              cur_txn = 1'b0;
              cur_be = '0;
            end
            cmd.write = 1'b1;
            cmd.widx = at;
            cmd.wdata = '{key: cur.key, backend: cur_be, txn: cur_txn, last_use: now_q};
            txn_d = cur_txn;
            hint_d = (cur_txn || sticky_q) ? cur_be : '0;
          end
        end
        REQ_END: begin
          if (hit_q) begin
            cmd.shift = 1'b1;
            cmd.sidx = hidx_q;
            count_d = count_q - 1'b1;
            status_d = ST_REMOVED;
          end else begin
            status_d = ST_ABSENT;
          end
        end
        REQ_BIND: begin
          if (hit_q) begin
            txn_d = cur.txn;
            if (cur.backend == '0) begin
              cmd.write = 1'b1;
              cmd.widx = hidx_q;
              cmd.wdata = '{key: cur.key, backend: acq_q, txn: cur.txn,
                            last_use: cur.last_use};
              hint_d = acq_q;
              status_d = ST_BOUND;
            end else begin
              hint_d = cur.backend;
              status_d = ST_NOT_BOUND;
            end
          end else begin
            status_d = ST_ABSENT;
          end
        end
        default: status_d = ST_NO_ENTRY;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_SCAN;
      S_SCAN: if (scan_last) state_d = S_UPD;
      S_UPD:  state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      scan_q <= '0;
      max_q <= 7'd64;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q <= (state_q == S_SCAN) ? scan_q + 1'b1 : '0;
      if (cfg_we_i) max_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      req_q <= req_type_i;
      key_q <= session_key_i;
      kind_q <= query_kind_i;
      sticky_q <= needs_sticky_i;
      now_q <= now_seconds_i;
      acq_q <= acquired_backend_i;
    end
    if (state_q == S_SCAN && scan_last) begin
      hit_q <= hit;
      hidx_q <= hidx;
      bvld_q <= bv[TableDepth];
      bidx_q <= bi[TableDepth];
    end
    status_q <= status_d;
    txn_q <= txn_d;
    hint_q <= hint_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);
  assign status_o = status_q;
  assign pinned_txn_o = txn_q;
  assign backend_hint_o = hint_q;
  assign live_entries_o = 7'(count_q);
endmodule
`default_nettype wire
